// ===== rtl/roi_pkg.sv =====
// shared types, widths and register codes for the ray/object intersection core
`timescale 1ns / 1ps

package roi_pkg;

    // coordinate format
    localparam int CW = 32;            // coordinate width
    localparam int FB = 16;            // fraction bits

    // derived datapath widths
    localparam int VW = CW + 1;        // origin minus center
    localparam int PW = 2 * VW;        // one product of a dot
    localparam int DW = PW + 2;        // sum of three products
    localparam int LW = DW / 2;        // limb of a wide square
    localparam int MW = 2 * DW;        // wide square or product
    localparam int QW = MW + 2;        // discriminant
    localparam int SW = QW / 2;        // square root, one bit per stage
    localparam int NW = SW + 1;        // numerator of the root formula
    localparam int RW = DW + CW + 1;   // divider remainder
    localparam int RRW = 2 * (CW - 1); // radius squared

    localparam int IDX_W = 3;

    // distance given on a miss: -1.0
    localparam logic [CW-1:0] MISS_DIST = {{(CW - FB){1'b1}}, {FB{1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_KIND     = 3'd0,
        REG_CENTER_X = 3'd1,
        REG_CENTER_Y = 3'd2,
        REG_CENTER_Z = 3'd3,
        REG_RADIUS   = 3'd4,
        REG_NORMAL_X = 3'd5,
        REG_NORMAL_Y = 3'd6,
        REG_NORMAL_Z = 3'd7
    } roi_reg_idx_t;

    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_PLANE  = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
    } roi_ray_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] distance;
    } roi_res_t;

    typedef struct packed {
        logic                 object_kind;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic [CW-2:0]        sphere_radius;
        logic signed [CW-1:0] plane_normal_x;
        logic signed [CW-1:0] plane_normal_y;
        logic signed [CW-1:0] plane_normal_z;
    } roi_cfg_t;

    // what travels beside the discriminant through the root stages
    typedef struct packed {
        logic                 hit;
        logic signed [DW-1:0] num;   // sphere: h, plane: (P - O).N
        logic signed [DW-1:0] den;   // sphere: a, plane: N.D
    } roi_side_t;

endpackage

// ===== rtl/roi_front.sv =====
// front stages: differences, dot products, wide squares and the discriminant
`timescale 1ns / 1ps

module roi_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       ray_valid,
    input  roi_pkg::roi_ray_t          ray,
    input  roi_pkg::roi_cfg_t          cfg,
    output logic                       q_valid,
    output logic [roi_pkg::QW-1:0]     q,
    output roi_pkg::roi_side_t         side
);

    localparam int CW = roi_pkg::CW;
    localparam int VW = roi_pkg::VW;
    localparam int PW = roi_pkg::PW;
    localparam int DW = roi_pkg::DW;
    localparam int LW = roi_pkg::LW;
    localparam int MW = roi_pkg::MW;
    localparam int QW = roi_pkg::QW;
    localparam int RRW = roi_pkg::RRW;
    localparam int NST = 7;

    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [CW-1:0] pos [3];
    logic signed [CW-1:0] nrm [3];

    // per-axis views of ray and object
    always_comb
    begin
        org[0] = ray.origin_x;
        org[1] = ray.origin_y;
        org[2] = ray.origin_z;
        dir[0] = ray.dir_x;
        dir[1] = ray.dir_y;
        dir[2] = ray.dir_z;
        pos[0] = cfg.center_x;
        pos[1] = cfg.center_y;
        pos[2] = cfg.center_z;
        nrm[0] = cfg.plane_normal_x;
        nrm[1] = cfg.plane_normal_y;
        nrm[2] = cfg.plane_normal_z;
    end

    logic [NST-1:0] vld_reg;
    logic [NST-2:0] dnz_reg;

    // stage 1
    logic signed [VW-1:0] v1_reg [3];
    logic signed [CW-1:0] d1_reg [3];
    // stage 2
    logic signed [PW-1:0] dd2_reg [3];
    logic signed [PW-1:0] vd2_reg [3];
    logic signed [PW-1:0] vv2_reg [3];
    logic signed [PW-1:0] nd2_reg [3];
    logic signed [PW-1:0] vn2_reg [3];
    logic [RRW-1:0]       rr2_reg;
    // stage 3
    logic signed [DW-1:0] a3_reg;
    logic signed [DW-1:0] h3_reg;
    logic signed [DW-1:0] vv3_reg;
    logic signed [DW-1:0] e3_reg;
    logic signed [DW-1:0] vn3_reg;
    logic [RRW-1:0]       rr3_reg;
    // stage 4
    logic [DW-1:0]        hmag4_reg;
    logic [DW-1:0]        amag4_reg;
    logic [DW-1:0]        cmag4_reg;
    logic                 cneg4_reg;
    logic signed [DW-1:0] num4_reg;
    logic signed [DW-1:0] den4_reg;
    // stage 5
    logic [DW-1:0]        hhh5_reg;
    logic [DW-1:0]        hhl5_reg;
    logic [DW-1:0]        hll5_reg;
    logic [DW-1:0]        ahh5_reg;
    logic [DW-1:0]        ahl5_reg;
    logic [DW-1:0]        alh5_reg;
    logic [DW-1:0]        all5_reg;
    logic                 cneg5_reg;
    logic signed [DW-1:0] num5_reg;
    logic signed [DW-1:0] den5_reg;
    // stage 6
    logic [MW-1:0]        hh6_reg;
    logic [MW-1:0]        ac6_reg;
    logic                 cneg6_reg;
    logic signed [DW-1:0] num6_reg;
    logic signed [DW-1:0] den6_reg;
    // stage 7
    logic [QW-1:0]        q7_reg;
    roi_pkg::roi_side_t   side7_reg;

    logic                 dnz_w;
    logic signed [DW-1:0] c_w;
    logic [DW-1:0]        hmag_w;
    logic [DW-1:0]        cmag_w;
    logic [QW-1:0]        q_w;
    logic                 qneg_w;

    assign dnz_w  = (ray.dir_x != '0) || (ray.dir_y != '0) || (ray.dir_z != '0);
    assign c_w    = vv3_reg - $signed(DW'(rr3_reg));
    assign hmag_w = h3_reg[DW-1] ? DW'(-h3_reg) : DW'(h3_reg);
    assign cmag_w = c_w[DW-1] ? DW'(-c_w) : DW'(c_w);
    assign q_w    = cneg6_reg ? (QW'(hh6_reg) + QW'(ac6_reg))
                              : (QW'(hh6_reg) - QW'(ac6_reg));
    assign qneg_w = q_w[QW-1];

    // valid and direction flags travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], ray_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnz_reg <= {dnz_reg[NST-3:0], dnz_w};

            // stage 1: origin relative to the center
            for (int i = 0; i < 3; i++)
            begin
                v1_reg[i] <= VW'(org[i]) - VW'(pos[i]);
                d1_reg[i] <= dir[i];
            end

            // stage 2: all single products
            for (int i = 0; i < 3; i++)
            begin
                dd2_reg[i] <= PW'(d1_reg[i]) * PW'(d1_reg[i]);
                vd2_reg[i] <= PW'(v1_reg[i]) * PW'(d1_reg[i]);
                vv2_reg[i] <= PW'(v1_reg[i]) * PW'(v1_reg[i]);
                nd2_reg[i] <= PW'(nrm[i]) * PW'(d1_reg[i]);
                vn2_reg[i] <= PW'(v1_reg[i]) * PW'(nrm[i]);
            end
            rr2_reg <= RRW'(cfg.sphere_radius) * RRW'(cfg.sphere_radius);

            // stage 3: dot product sums
            a3_reg  <= DW'(dd2_reg[0]) + DW'(dd2_reg[1]) + DW'(dd2_reg[2]);
            h3_reg  <= DW'(vd2_reg[0]) + DW'(vd2_reg[1]) + DW'(vd2_reg[2]);
            vv3_reg <= DW'(vv2_reg[0]) + DW'(vv2_reg[1]) + DW'(vv2_reg[2]);
            e3_reg  <= DW'(nd2_reg[0]) + DW'(nd2_reg[1]) + DW'(nd2_reg[2]);
            vn3_reg <= DW'(vn2_reg[0]) + DW'(vn2_reg[1]) + DW'(vn2_reg[2]);
            rr3_reg <= rr2_reg;

            // stage 4: magnitudes, pick numerator and denominator by kind
            hmag4_reg <= hmag_w;
            amag4_reg <= DW'(a3_reg);
            cmag4_reg <= cmag_w;
            cneg4_reg <= c_w[DW-1];
            num4_reg  <= (cfg.object_kind == roi_pkg::KIND_PLANE) ? -vn3_reg : h3_reg;
            den4_reg  <= (cfg.object_kind == roi_pkg::KIND_PLANE) ? e3_reg : a3_reg;

            // stage 5: limb partial products of h*h and a*c
            hhh5_reg  <= DW'(hmag4_reg[DW-1:LW]) * DW'(hmag4_reg[DW-1:LW]);
            hhl5_reg  <= DW'(hmag4_reg[DW-1:LW]) * DW'(hmag4_reg[LW-1:0]);
            hll5_reg  <= DW'(hmag4_reg[LW-1:0]) * DW'(hmag4_reg[LW-1:0]);
            ahh5_reg  <= DW'(amag4_reg[DW-1:LW]) * DW'(cmag4_reg[DW-1:LW]);
            ahl5_reg  <= DW'(amag4_reg[DW-1:LW]) * DW'(cmag4_reg[LW-1:0]);
            alh5_reg  <= DW'(amag4_reg[LW-1:0]) * DW'(cmag4_reg[DW-1:LW]);
            all5_reg  <= DW'(amag4_reg[LW-1:0]) * DW'(cmag4_reg[LW-1:0]);
            cneg5_reg <= cneg4_reg;
            num5_reg  <= num4_reg;
            den5_reg  <= den4_reg;

            // stage 6: assemble the wide products
            hh6_reg   <= (MW'(hhh5_reg) << DW) + (MW'(hhl5_reg) << (LW + 1))
                         + MW'(hll5_reg);
            ac6_reg   <= (MW'(ahh5_reg) << DW)
                         + ((MW'(ahl5_reg) + MW'(alh5_reg)) << LW) + MW'(all5_reg);
            cneg6_reg <= cneg5_reg;
            num6_reg  <= num5_reg;
            den6_reg  <= den5_reg;

            // stage 7: discriminant and hit decision
            q7_reg         <= qneg_w ? '0 : q_w;
            side7_reg.hit  <= dnz_reg[5] &&
                              ((cfg.object_kind == roi_pkg::KIND_PLANE) ? (den6_reg != '0)
                                                                        : !qneg_w);
            side7_reg.num  <= num6_reg;
            side7_reg.den  <= den6_reg;
        end
    end

    assign q_valid = vld_reg[NST-1];
    assign q       = q7_reg;
    assign side    = side7_reg;

endmodule

// ===== rtl/roi_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module roi_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [roi_pkg::QW-1:0] x,
    input  roi_pkg::roi_side_t     side_in,
    output logic                   out_valid,
    output logic [roi_pkg::SW-1:0] root,
    output roi_pkg::roi_side_t     side_out
);

    localparam int QW = roi_pkg::QW;
    localparam int SW = roi_pkg::SW;
    localparam int XW = SW + 2;

    logic [SW-1:0]      vld_reg;
    logic [QW-1:0]      x_reg    [SW];
    logic [XW-1:0]      rem_reg  [SW];
    logic [SW-1:0]      root_reg [SW];
    roi_pkg::roi_side_t side_reg [SW];

    logic [QW-1:0]      x_next    [SW];
    logic [XW-1:0]      rem_next  [SW];
    logic [SW-1:0]      root_next [SW];

    logic [QW-1:0]      src_x    [SW];
    logic [XW-1:0]      src_rem  [SW];
    logic [SW-1:0]      src_root [SW];
    logic [XW-1:0]      rem_sh   [SW];
    logic [XW-1:0]      trial    [SW];
    logic               ge       [SW];

    // one restoring step per stage: bring down two bits, try root*4+1
    always_comb
    begin
        for (int k = 0; k < SW; k++)
        begin
            src_x[k]    = (k == 0) ? x  : x_reg[(k == 0) ? 0 : k - 1];
            src_rem[k]  = (k == 0) ? '0 : rem_reg[(k == 0) ? 0 : k - 1];
            src_root[k] = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            rem_sh[k]   = {src_rem[k][SW-1:0], src_x[k][QW-1:QW-2]};
            trial[k]    = {src_root[k], 2'b01};
            ge[k]       = rem_sh[k] >= trial[k];
            rem_next[k] = ge[k] ? (rem_sh[k] - trial[k]) : rem_sh[k];
            root_next[k] = {src_root[k][SW-2:0], ge[k]};
            x_next[k]   = {src_x[k][QW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SW; k++)
            begin
                x_reg[k]    <= x_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = vld_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign side_out  = side_reg[SW-1];

endmodule

// ===== rtl/roi_div.sv =====
// numerator setup, pipelined restoring divider and saturation to the output
`timescale 1ns / 1ps

module roi_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [roi_pkg::SW-1:0] root,
    input  roi_pkg::roi_side_t     side,
    input  logic                   kind,
    output logic                   res_valid,
    output roi_pkg::roi_res_t      res
);

    localparam int CW = roi_pkg::CW;
    localparam int FB = roi_pkg::FB;
    localparam int DW = roi_pkg::DW;
    localparam int NW = roi_pkg::NW;
    localparam int RW = roi_pkg::RW;
    localparam logic [CW-1:0] HALF = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW - 1){1'b1}}};

    // numerator stage
    logic signed [NW-1:0] s_w;
    logic signed [NW-1:0] fnum_w;
    logic signed [NW-1:0] num_w;
    logic [NW-1:0]        nmag_w;
    logic [DW-1:0]        dmag_w;

    assign s_w    = $signed({1'b0, root});
    assign fnum_w = NW'(side.num);
    assign num_w  = (kind == roi_pkg::KIND_PLANE) ? fnum_w : (-fnum_w - s_w);
    assign nmag_w = num_w[NW-1] ? NW'(-num_w) : NW'(num_w);
    assign dmag_w = side.den[DW-1] ? DW'(-side.den) : DW'(side.den);

    logic          n0_vld_reg;
    logic          n0_hit_reg;
    logic          n0_neg_reg;
    logic [DW-1:0] n0_den_reg;
    logic [RW-1:0] n0_dvd_reg;

    logic          n1_vld_reg;
    logic          n1_hit_reg;
    logic          n1_neg_reg;
    logic          n1_big_reg;
    logic [DW-1:0] n1_den_reg;
    logic [RW-1:0] n1_rem_reg;

    // divider stages, one quotient bit each
    logic [CW-1:0] dv_vld_reg;
    logic          dv_hit_reg [CW];
    logic          dv_neg_reg [CW];
    logic          dv_big_reg [CW];
    logic [DW-1:0] dv_den_reg [CW];
    logic [RW-1:0] dv_rem_reg [CW];
    logic [CW-1:0] dv_quo_reg [CW];

    logic [DW-1:0] src_den  [CW];
    logic [RW-1:0] src_rem  [CW];
    logic [CW-1:0] src_quo  [CW];
    logic [RW-1:0] dsh      [CW];
    logic          ge       [CW];
    logic [RW-1:0] rem_next [CW];
    logic [CW-1:0] quo_next [CW];

    always_comb
    begin
        for (int k = 0; k < CW; k++)
        begin
            src_den[k]  = (k == 0) ? n1_den_reg : dv_den_reg[(k == 0) ? 0 : k - 1];
            src_rem[k]  = (k == 0) ? n1_rem_reg : dv_rem_reg[(k == 0) ? 0 : k - 1];
            src_quo[k]  = (k == 0) ? '0 : dv_quo_reg[(k == 0) ? 0 : k - 1];
            dsh[k]      = RW'(src_den[k]) << (CW - 1 - k);
            ge[k]       = src_rem[k] >= dsh[k];
            rem_next[k] = ge[k] ? (src_rem[k] - dsh[k]) : src_rem[k];
            quo_next[k] = {src_quo[k][CW-2:0], ge[k]};
        end
    end

    // saturation of the final quotient
    logic [CW-1:0] v_w;
    logic [CW-1:0] sat_w;
    logic          last_big;
    logic          last_neg;

    assign v_w      = dv_quo_reg[CW-1];
    assign last_big = dv_big_reg[CW-1];
    assign last_neg = dv_neg_reg[CW-1];

    always_comb
    begin
        if (last_neg)
        begin
            sat_w = (last_big || (v_w > HALF)) ? HALF : (~v_w + 1'b1);
        end
        else
        begin
            sat_w = (last_big || v_w[CW-1]) ? POS_MAX : v_w;
        end
    end

    logic              res_valid_reg;
    roi_pkg::roi_res_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n0_vld_reg    <= 1'b0;
            n1_vld_reg    <= 1'b0;
            dv_vld_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            n0_vld_reg    <= in_valid;
            n1_vld_reg    <= n0_vld_reg;
            dv_vld_reg    <= {dv_vld_reg[CW-2:0], n1_vld_reg};
            res_valid_reg <= dv_vld_reg[CW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // signed operands to magnitudes, scale the dividend
            n0_hit_reg <= side.hit;
            n0_neg_reg <= num_w[NW-1] ^ side.den[DW-1];
            n0_den_reg <= dmag_w;
            n0_dvd_reg <= RW'(nmag_w) << FB;

            // quotient beyond the result width saturates
            n1_hit_reg <= n0_hit_reg;
            n1_neg_reg <= n0_neg_reg;
            n1_big_reg <= n0_dvd_reg >= (RW'(n0_den_reg) << CW);
            n1_den_reg <= n0_den_reg;
            n1_rem_reg <= n0_dvd_reg;

            for (int k = 0; k < CW; k++)
            begin
                dv_hit_reg[k] <= (k == 0) ? n1_hit_reg : dv_hit_reg[(k == 0) ? 0 : k - 1];
                dv_neg_reg[k] <= (k == 0) ? n1_neg_reg : dv_neg_reg[(k == 0) ? 0 : k - 1];
                dv_big_reg[k] <= (k == 0) ? n1_big_reg : dv_big_reg[(k == 0) ? 0 : k - 1];
                dv_den_reg[k] <= src_den[k];
                dv_rem_reg[k] <= rem_next[k];
                dv_quo_reg[k] <= quo_next[k];
            end

            // output register
            res_reg.hit      <= dv_hit_reg[CW-1];
            res_reg.distance <= dv_hit_reg[CW-1] ? sat_w : roi_pkg::MISS_DIST;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/ray_object_intersection_core.sv =====
// Ray against one sphere or plane: each ray in gives one hit flag and distance out.
// Rays enter on ray_data with ray_valid/ray_stall; a transfer happens on a rising
// edge with ray_valid high and ray_stall low. Results leave on res_data with
// res_valid/res_stall under the same rule. Object kind, position, radius and plane
// normal are loaded through cfg_wr_en/cfg_index/cfg_data; the user must do so only
// while no ray is in flight, not enforced by the block. All registers reset to zero
// (a sphere of radius zero at the origin). One ray is accepted every cycle with
// ray_stall low. Stages: 7 front (dot products, wide squares, discriminant), 69
// square root at one root bit each, 2 for the numerator and overflow test, 32
// divider at one quotient bit each, and the output register. The whole pipeline
// moves on one enable: when a result is held by res_stall, every stage holds and
// ray_stall is raised in the same cycle, so nothing is lost or repeated. Reset
// (rst_n low, asynchronous) clears every valid bit and the configuration.
`timescale 1ns / 1ps

module ray_object_intersection_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ray_valid,
    output logic                          ray_stall,
    input  roi_pkg::roi_ray_t             ray_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output roi_pkg::roi_res_t             res_data,
    input  logic                          cfg_wr_en,
    input  logic [roi_pkg::IDX_W-1:0]     cfg_index,
    input  logic [roi_pkg::CW-1:0]        cfg_data
);

    localparam int CW = roi_pkg::CW;

    roi_pkg::roi_cfg_t cfg_reg;
    logic              en;

    // global advance: output empty or being taken
    assign en        = !res_valid || !res_stall;
    assign ray_stall = !en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                roi_pkg::REG_KIND:     cfg_reg.object_kind    <= cfg_data[0];
                roi_pkg::REG_CENTER_X: cfg_reg.center_x       <= cfg_data;
                roi_pkg::REG_CENTER_Y: cfg_reg.center_y       <= cfg_data;
                roi_pkg::REG_CENTER_Z: cfg_reg.center_z       <= cfg_data;
                roi_pkg::REG_RADIUS:   cfg_reg.sphere_radius  <= cfg_data[CW-2:0];
                roi_pkg::REG_NORMAL_X: cfg_reg.plane_normal_x <= cfg_data;
                roi_pkg::REG_NORMAL_Y: cfg_reg.plane_normal_y <= cfg_data;
                roi_pkg::REG_NORMAL_Z: cfg_reg.plane_normal_z <= cfg_data;
                default:               cfg_reg                <= cfg_reg;
            endcase
        end
    end

    logic                   front_vld;
    logic [roi_pkg::QW-1:0] front_q;
    roi_pkg::roi_side_t     front_side;

    logic                   sqrt_vld;
    logic [roi_pkg::SW-1:0] sqrt_root;
    roi_pkg::roi_side_t     sqrt_side;

    roi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ray_valid (ray_valid),
        .ray       (ray_data),
        .cfg       (cfg_reg),
        .q_valid   (front_vld),
        .q         (front_q),
        .side      (front_side)
    );

    roi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_vld),
        .x         (front_q),
        .side_in   (front_side),
        .out_valid (sqrt_vld),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    roi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_vld),
        .root      (sqrt_root),
        .side      (sqrt_side),
        .kind      (cfg_reg.object_kind),
        .res_valid (res_valid),
        .res       (res_data)
    );

    // a miss always carries the miss distance
    a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.hit |-> res_data.distance == roi_pkg::MISS_DIST)
        else $error("miss result without miss distance");

    // a held pipeline keeps its inner valid bits
    a_hold_inner: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(front_vld) && $stable(sqrt_vld))
        else $error("inner stage moved while output stalled");

    // a held output keeps the front of the pipeline closed
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> ray_stall)
        else $error("ray taken while result stalled");

endmodule
